[hw/rtl/mme_pkg.sv]
// Shared types and constants for the matrix multiply engine.
package mme_pkg;

  localparam int IDX_W     = 3;   // row / column index width
  localparam int VAL_W     = 16;  // Q8.8 element width
  localparam int PROD_W    = 32;  // Q16.16 product width
  localparam int RES_W     = 40;  // Q24.16 sum width
  localparam int DIM_W     = 4;   // shape register width
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH    = 4;   // command queue depth
  localparam int QPTR_W    = 2;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_START  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_STORE_A = 2'd0,
    OP_STORE_B = 2'd1,
    OP_ERROR   = 2'd2,
    OP_START   = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } job_t;

  // effective (clamped) matrix shape
  typedef struct packed {
    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nk;
    logic [DIM_W-1:0] nc;
  } dims_t;

endpackage

[hw/rtl/matrix_multiply_engine_unit.sv]
// Top level of the dense matrix multiply engine.
//
// Computes C = A * B over signed Q8.8 elements with exact 40-bit Q24.16
// sums. Input transfers carry a command: load A element, load B element,
// or start. Loads inside the configured shape are stored silently; a load
// outside it produces one result with index_error set (in tuser), the
// offending row/column and a zero value. A start streams out every element
// of C row by row, column by column, with tlast on the final element. The
// shape registers (rows_a, inner_dim, cols_b) are written through the cfg
// channel; the user must write them only while the engine is idle, which
// the block itself does not enforce. 0 acts as 1 and values above MAX_DIM
// act as MAX_DIM. Reading a store entry that was never loaded gives an
// unspecified value. Items pass from a front end through a four-entry job
// queue to the back end, so input can keep flowing while results stall,
// until the queue is full. A start runs one multiply-accumulate per cycle
// while the result output is not stalled, on a single multiplier fed by
// one read port on each store.
module matrix_multiply_engine_unit #(
  parameter int MAX_DIM = 8
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // command[1:0], row_index[4:2], col_index[7:5],
                                      // element_value[23:8]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_row[2:0], out_col[5:3], out_value[45:6], zero pad
  output logic        m_axis_tlast,   // last
  output logic        m_axis_tuser,   // index_error
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  logic [mme_pkg::DIM_W-1:0] rows_a, inner_dim, cols_b;
  mme_pkg::dims_t            dims;

  logic                      q_push, q_pop, q_full, q_empty;
  mme_pkg::job_t             push_job, q_head;

  logic [mme_pkg::IDX_W-1:0] out_row, out_col;
  logic [mme_pkg::RES_W-1:0] out_value;

  // clamp a shape register to 1..MAX_DIM
  function automatic logic [mme_pkg::DIM_W-1:0] clamp_dim(input logic [mme_pkg::DIM_W-1:0] v);
    logic [mme_pkg::DIM_W-1:0] r;
    if (v == '0) begin
      r = mme_pkg::DIM_W'(1);
    end else if (v > mme_pkg::DIM_W'(MAX_DIM)) begin
      r = mme_pkg::DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign dims.nr = clamp_dim(rows_a);
  assign dims.nk = clamp_dim(inner_dim);
  assign dims.nc = clamp_dim(cols_b);

  // config registers keep the written bits; clamping happens on use
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= mme_pkg::DIM_W'(8);
      inner_dim <= mme_pkg::DIM_W'(8);
      cols_b    <= mme_pkg::DIM_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mme_pkg::REG_ROWS_A:    rows_a    <= cfg_data;
        mme_pkg::REG_INNER_DIM: inner_dim <= cfg_data;
        mme_pkg::REG_COLS_B:    cols_b    <= cfg_data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  mme_front u_front (
    .dims          (dims),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .command       (s_axis_tdata[1:0]),
    .row_index     (s_axis_tdata[4:2]),
    .col_index     (s_axis_tdata[7:5]),
    .element_value (s_axis_tdata[23:8]),
    .q_full        (q_full),
    .push          (q_push),
    .job           (push_job)
  );

  mme_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  mme_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk       (clk),
    .rst       (rst),
    .dims      (dims),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (m_axis_tlast),
    .out_err   (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, out_value, out_col, out_row};

endmodule

[hw/rtl/mme_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/mme_front.sv]
// Front end: accepts input items, checks load bounds and classifies them into jobs.
module mme_front (
  input  mme_pkg::dims_t                 dims,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     command,
  input  logic [mme_pkg::IDX_W-1:0]      row_index,
  input  logic [mme_pkg::IDX_W-1:0]      col_index,
  input  logic [mme_pkg::VAL_W-1:0]      element_value,
  input  logic                           q_full,
  output logic                           push,
  output mme_pkg::job_t                  job
);

  logic                      keep;
  logic                      is_load;
  logic [mme_pkg::DIM_W-1:0] lim_r;
  logic [mme_pkg::DIM_W-1:0] lim_c;
  logic                      bad;

  always_comb begin
    keep    = 1'b1;
    is_load = 1'b1;
    lim_r   = dims.nr;
    lim_c   = dims.nk;
    unique case (command)
      mme_pkg::CMD_LOAD_A: begin
        lim_r = dims.nr;
        lim_c = dims.nk;
      end
      mme_pkg::CMD_LOAD_B: begin
        lim_r = dims.nk;
        lim_c = dims.nc;
      end
      mme_pkg::CMD_START: begin
        is_load = 1'b0;
      end
      default: begin
        // unused code: taken and dropped
        keep    = 1'b0;
        is_load = 1'b0;
      end
    endcase

    bad = ({1'b0, row_index} >= lim_r) || ({1'b0, col_index} >= lim_c);

    job.row   = row_index;
    job.col   = col_index;
    job.value = element_value;
    if (!is_load) begin
      job.op = mme_pkg::OP_START;
    end else if (bad) begin
      job.op = mme_pkg::OP_ERROR;
    end else if (command == mme_pkg::CMD_LOAD_A) begin
      job.op = mme_pkg::OP_STORE_A;
    end else begin
      job.op = mme_pkg::OP_STORE_B;
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready && keep;

endmodule

[hw/rtl/mme_queue.sv]
// Short job queue between front and back end.
module mme_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mme_pkg::job_t push_job,
  input  logic          pop,
  output mme_pkg::job_t head,
  output logic          full,
  output logic          empty
);

  mme_pkg::job_t               entries [mme_pkg::QDEPTH];
  logic [mme_pkg::QPTR_W-1:0]  wr_ptr;
  logic [mme_pkg::QPTR_W-1:0]  rd_ptr;
  logic [mme_pkg::QPTR_W:0]    count;

  assign full  = (count == (mme_pkg::QPTR_W+1)'(mme_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_job;
        wr_ptr          <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/mme_back.sv]
// Back end: executes jobs, holds the A/B stores and runs the multiply-accumulate pipeline.
module mme_back #(
  parameter int MAX_DIM = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mme_pkg::dims_t                dims,
  input  logic                          q_empty,
  input  mme_pkg::job_t                 q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mme_pkg::IDX_W-1:0]     out_row,
  output logic [mme_pkg::IDX_W-1:0]     out_col,
  output logic [mme_pkg::RES_W-1:0]     out_value,
  output logic                          out_last,
  output logic                          out_err
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                       state;
  logic [mme_pkg::IDX_W-1:0]    i, j, k;
  logic                         en, pipe_empty, issue;
  logic                         last_k, last_j, last_i;

  // stage 1: RAM read data
  logic                         s1_v, s1_first, s1_lastk, s1_lastall;
  logic [mme_pkg::IDX_W-1:0]    s1_i, s1_j;
  // stage 2: product
  logic                         s2_v, s2_first, s2_lastk, s2_lastall;
  logic [mme_pkg::IDX_W-1:0]    s2_i, s2_j;
  logic signed [mme_pkg::PROD_W-1:0] prod;

  logic signed [mme_pkg::RES_W-1:0]  acc, sum;

  logic                         a_we, b_we;
  logic [AW-1:0]                waddr, a_raddr, b_raddr;
  logic [mme_pkg::VAL_W-1:0]    a_rdata, b_rdata;

  assign en         = !out_valid || out_ready;
  assign pipe_empty = !s1_v && !s2_v;
  assign q_pop      = (state == ST_IDLE) && !q_empty && en && pipe_empty;
  assign issue      = (state == ST_RUN) && en;

  assign last_k = ({1'b0, k} + 1'b1) == dims.nk;
  assign last_j = ({1'b0, j} + 1'b1) == dims.nc;
  assign last_i = ({1'b0, i} + 1'b1) == dims.nr;

  assign waddr   = AW'(q_head.row * MAX_DIM + q_head.col);
  assign a_raddr = AW'(i * MAX_DIM + k);
  assign b_raddr = AW'(k * MAX_DIM + j);
  assign a_we    = q_pop && (q_head.op == mme_pkg::OP_STORE_A);
  assign b_we    = q_pop && (q_head.op == mme_pkg::OP_STORE_B);

  mme_ram #(.WIDTH(mme_pkg::VAL_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (q_head.value),
    .re    (en),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mme_ram #(.WIDTH(mme_pkg::VAL_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (q_head.value),
    .re    (en),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign sum = (s2_first ? '0 : acc) + {{(mme_pkg::RES_W-mme_pkg::PROD_W){prod[mme_pkg::PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_v       <= issue;
      s1_i       <= i;
      s1_j       <= j;
      s1_first   <= (k == '0);
      s1_lastk   <= last_k;
      s1_lastall <= last_k && last_j && last_i;

      s2_v       <= s1_v;
      s2_i       <= s1_i;
      s2_j       <= s1_j;
      s2_first   <= s1_first;
      s2_lastk   <= s1_lastk;
      s2_lastall <= s1_lastall;
      prod       <= $signed(a_rdata) * $signed(b_rdata);

      out_valid <= 1'b0;
      if (s2_v) begin
        if (s2_lastk) begin
          out_valid <= 1'b1;
          out_row   <= s2_i;
          out_col   <= s2_j;
          out_value <= sum;
          out_last  <= s2_lastall;
          out_err   <= 1'b0;
        end else begin
          acc <= sum;
        end
      end

      if (q_pop) begin
        unique case (q_head.op)
          mme_pkg::OP_ERROR: begin
            out_valid <= 1'b1;
            out_row   <= q_head.row;
            out_col   <= q_head.col;
            out_value <= '0;
            out_last  <= 1'b0;
            out_err   <= 1'b1;
          end
          mme_pkg::OP_START: begin
            state <= ST_RUN;
            i     <= '0;
            j     <= '0;
            k     <= '0;
          end
          default: ;  // stores go straight to the RAM write ports
        endcase
      end

      if (issue) begin
        if (!last_k) begin
          k <= k + 1'b1;
        end else begin
          k <= '0;
          if (!last_j) begin
            j <= j + 1'b1;
          end else begin
            j <= '0;
            if (!last_i) begin
              i <= i + 1'b1;
            end else begin
              i     <= '0;
              state <= ST_IDLE;
            end
          end
        end
      end
    end
  end

  // a new job is only taken once the MAC pipeline has drained
  a_pop_drained: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (pipe_empty && state == ST_IDLE))
    else $error("job popped while MAC pipeline busy");

  // error results carry a zero value and never close the matrix
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_err) |-> (out_value == '0 && !out_last))
    else $error("malformed error result");

  // the closing result sits at the bottom-right corner of C
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |->
      ({1'b0, out_row} == dims.nr - 1'b1 && {1'b0, out_col} == dims.nc - 1'b1))
    else $error("last flag on wrong element");

  // no new result is loaded while the previous one is stalled
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_last)))
    else $error("stalled result overwritten");

endmodule
